// File: rtl/playfair_digraph_encryptor_assert.svh
// Assertion macros shared by the Playfair encryptor RTL.
`ifndef PLAYFAIR_DIGRAPH_ENCRYPTOR_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pfe_pkg.sv
// Types and constants of the Playfair digraph encryptor.
package pfe_pkg;

    localparam int unsigned LETTER_W  = 5;
    localparam int unsigned SQ_SIZE   = 5;
    localparam int unsigned ROW_W     = LETTER_W * SQ_SIZE;
    localparam int unsigned CELLS     = SQ_SIZE * SQ_SIZE;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;
    localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_ZERO  = 3'd0,
        REG_ROW_ONE   = 3'd1,
        REG_ROW_TWO   = 3'd2,
        REG_ROW_THREE = 3'd3,
        REG_ROW_FOUR  = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic [LETTER_W-1:0] plain_letter;
        logic                word_end;
    } t_in_item;

    typedef struct packed {
        logic [LETTER_W-1:0] cipher_letter;
        logic                run_last;
    } t_out_item;

endpackage

// File: rtl/playfair_digraph_encryptor.sv
// Playfair digraph encryptor: pairing front end, square lookup and letter serialiser.
// Usage:
//   Plaintext letters (a=0 .. z=25) enter on the i_in_valid / o_in_ready channel,
//   each with a word_end flag. J is folded onto I, letters are paired, a doubled
//   letter gets an X after it and an odd word is padded with X. Each pair is
//   encrypted against the 5x5 key square held in five row registers.
//   The square is written through the i_cfg_valid / o_cfg_ready channel
//   (index 0..4 selects the row, other indexes are ignored); write it only
//   while the block is idle. o_cfg_ready is always high.
//   Ciphertext leaves one letter per transfer on o_out_valid / i_out_ready;
//   run_last marks the final letter caused by an input letter.
// Timing:
//   A completed pair is written to the pair register and then moves into the
//   output register, which offers its first letter; a busy output register
//   holds it there. An input causes 0, 2 or 4 output letters, so the single
//   letter output port sets the rate: one output letter per cycle while
//   i_out_ready is high. A new input is taken every cycle while the pair register can
//   drain into the output register. A stalled receiver holds the output letter;
//   one more pair then waits in the pair register before o_in_ready drops.
// Reset: synchronous, active low; clears the square, the held letter and all valid flags.
module playfair_digraph_encryptor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  pfe_pkg::t_in_item              i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output pfe_pkg::t_out_item             o_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pfe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfe_pkg::ROW_W-1:0]      i_cfg_data
);
    import pfe_pkg::*;

    // Key square, row r in r_square[r], column c at bits 5c.
    logic [SQ_SIZE-1:0][ROW_W-1:0] r_square;

    // Held first letter of an open pair.
    logic                r_pend_valid, n_pend_valid;
    logic [LETTER_W-1:0] r_pend_letter, n_pend_letter;

    // Pair register: letters to encrypt and whether the pair is sent twice.
    logic                r_job_valid, n_job_valid;
    logic [LETTER_W-1:0] r_job_a, n_job_a;
    logic [LETTER_W-1:0] r_job_b, n_job_b;
    logic                r_job_rep, n_job_rep;

    // Output register: encrypted pair and position within the run.
    logic                r_res_valid, n_res_valid;
    logic [LETTER_W-1:0] r_res_c0, n_res_c0;
    logic [LETTER_W-1:0] r_res_c1, n_res_c1;
    logic                r_res_rep, n_res_rep;
    logic [1:0]          r_res_idx, n_res_idx;

    logic                in_xfer, out_xfer, res_done, res_load, job_move, job_new;
    logic [LETTER_W-1:0] in_letter;

    logic [CELLS-1:0]    pos_a, pos_b;
    logic [SQ_SIZE-1:0] row_a, col_a, row_b, col_b;
    logic [SQ_SIZE-1:0] trow_a, tcol_a, trow_b, tcol_b;
    logic [LETTER_W-1:0] enc_a, enc_b;

    // First match in row-major order, cell zero when the letter is absent.
    function automatic logic [CELLS-1:0] f_locate(
        input logic [LETTER_W-1:0]           letter,
        input logic [SQ_SIZE-1:0][ROW_W-1:0] sq
    );
        logic [CELLS-1:0] m;
        logic [CELLS-1:0] oh;
        for (int r = 0; r < SQ_SIZE; r++) begin
            for (int c = 0; c < SQ_SIZE; c++) begin
                m[r*SQ_SIZE + c] = (sq[r][c*LETTER_W +: LETTER_W] == letter);
            end
        end
        oh = m & (~m + CELLS'(1));
        if (m == '0) begin
            oh = CELLS'(1);
        end
        return oh;
    endfunction

    function automatic logic [SQ_SIZE-1:0] f_row(input logic [CELLS-1:0] oh);
        logic [SQ_SIZE-1:0] row;
        for (int r = 0; r < SQ_SIZE; r++) begin
            row[r] = |oh[r*SQ_SIZE +: SQ_SIZE];
        end
        return row;
    endfunction

    function automatic logic [SQ_SIZE-1:0] f_col(input logic [CELLS-1:0] oh);
        logic [SQ_SIZE-1:0] col;
        col = '0;
        for (int r = 0; r < SQ_SIZE; r++) begin
            col = col | oh[r*SQ_SIZE +: SQ_SIZE];
        end
        return col;
    endfunction

    // Rotate a one-hot position by one place with wrap.
    function automatic logic [SQ_SIZE-1:0] f_step(input logic [SQ_SIZE-1:0] oh);
        return {oh[SQ_SIZE-2:0], oh[SQ_SIZE-1]};
    endfunction

    // AND-OR read of the cell at one-hot row and column.
    function automatic logic [LETTER_W-1:0] f_pick(
        input logic [SQ_SIZE-1:0]            row,
        input logic [SQ_SIZE-1:0]            col,
        input logic [SQ_SIZE-1:0][ROW_W-1:0] sq
    );
        logic [LETTER_W-1:0] v;
        v = '0;
        for (int r = 0; r < SQ_SIZE; r++) begin
            for (int c = 0; c < SQ_SIZE; c++) begin
                if (row[r] && col[c]) begin
                    v = v | sq[r][c*LETTER_W +: LETTER_W];
                end
            end
        end
        return v;
    endfunction

    assign o_cfg_ready = 1'b1;

    // Handshakes.
    assign out_xfer    = r_res_valid && i_out_ready;
    assign res_done    = out_xfer && o_out.run_last;
    assign res_load    = !r_res_valid || res_done;
    assign job_move    = r_job_valid && res_load;
    assign o_in_ready  = !r_job_valid || res_load;
    assign in_xfer     = i_in_valid && o_in_ready;

    // Pairing front end.
    assign in_letter = (i_in.plain_letter == LETTER_J) ? LETTER_I : i_in.plain_letter;
    assign job_new   = in_xfer && (r_pend_valid || i_in.word_end);

    always_comb begin
        n_pend_valid  = r_pend_valid;
        n_pend_letter = r_pend_letter;
        n_job_a       = r_job_a;
        n_job_b       = r_job_b;
        n_job_rep     = r_job_rep;
        n_job_valid   = r_job_valid && !job_move;
        if (in_xfer) begin
            if (!r_pend_valid) begin
                n_job_a   = in_letter;
                n_job_b   = LETTER_X;
                n_job_rep = 1'b0;
                if (!i_in.word_end) begin
                    n_pend_valid  = 1'b1;
                    n_pend_letter = in_letter;
                end
            end else if (r_pend_letter != in_letter) begin
                n_job_a       = r_pend_letter;
                n_job_b       = in_letter;
                n_job_rep     = 1'b0;
                n_pend_valid  = 1'b0;
                n_pend_letter = '0;
            end else begin
                // Doubled letter: pad with X; at word end the same pair goes twice.
                n_job_a   = r_pend_letter;
                n_job_b   = LETTER_X;
                n_job_rep = i_in.word_end;
                if (i_in.word_end) begin
                    n_pend_valid  = 1'b0;
                    n_pend_letter = '0;
                end
            end
        end
        if (job_new) begin
            n_job_valid = 1'b1;
        end
    end

    // Square lookup and Playfair rules on the pair register.
    always_comb begin
        pos_a  = f_locate(r_job_a, r_square);
        pos_b  = f_locate(r_job_b, r_square);
        row_a  = f_row(pos_a);
        col_a  = f_col(pos_a);
        row_b  = f_row(pos_b);
        col_b  = f_col(pos_b);
        trow_a = row_a;
        tcol_a = col_a;
        trow_b = row_b;
        tcol_b = col_b;
        if (row_a == row_b) begin
            tcol_a = f_step(col_a);
            tcol_b = f_step(col_b);
        end else if (col_a == col_b) begin
            trow_a = f_step(row_a);
            trow_b = f_step(row_b);
        end else begin
            tcol_a = col_b;
            tcol_b = col_a;
        end
        enc_a = f_pick(trow_a, tcol_a, r_square);
        enc_b = f_pick(trow_b, tcol_b, r_square);
    end

    // Output serialiser.
    always_comb begin
        n_res_valid = r_res_valid;
        n_res_c0    = r_res_c0;
        n_res_c1    = r_res_c1;
        n_res_rep   = r_res_rep;
        n_res_idx   = r_res_idx;
        if (res_load) begin
            n_res_valid = r_job_valid;
            n_res_c0    = enc_a;
            n_res_c1    = enc_b;
            n_res_rep   = r_job_rep;
            n_res_idx   = '0;
        end else if (out_xfer) begin
            n_res_idx = r_res_idx + 2'd1;
        end
    end

    assign o_out_valid         = r_res_valid;
    assign o_out.cipher_letter = r_res_idx[0] ? r_res_c1 : r_res_c0;
    assign o_out.run_last      = r_res_idx[0] && (!r_res_rep || r_res_idx[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square      <= '0;
            r_pend_valid  <= 1'b0;
            r_pend_letter <= '0;
            r_job_valid   <= 1'b0;
            r_res_valid   <= 1'b0;
            r_res_idx     <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_ROW_ZERO:  r_square[0] <= i_cfg_data;
                    REG_ROW_ONE:   r_square[1] <= i_cfg_data;
                    REG_ROW_TWO:   r_square[2] <= i_cfg_data;
                    REG_ROW_THREE: r_square[3] <= i_cfg_data;
                    REG_ROW_FOUR:  r_square[4] <= i_cfg_data;
                    default: ;
                endcase
            end
            r_pend_valid  <= n_pend_valid;
            r_pend_letter <= n_pend_letter;
            r_job_valid   <= n_job_valid;
            r_res_valid   <= n_res_valid;
            r_res_idx     <= n_res_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job_a   <= n_job_a;
        r_job_b   <= n_job_b;
        r_job_rep <= n_job_rep;
        r_res_c0  <= n_res_c0;
        r_res_c1  <= n_res_c1;
        r_res_rep <= n_res_rep;
    end

`include "playfair_digraph_encryptor_assert.svh"

    `PFE_ASSERT_SAME(a_pend_clear, i_clk, i_rst_n, !r_pend_valid,
        r_pend_letter == '0, "held letter not cleared")
    `PFE_ASSERT_SAME(a_pend_no_j, i_clk, i_rst_n, r_pend_valid,
        r_pend_letter != LETTER_J, "held letter is J")
    `PFE_ASSERT_SAME(a_stall_full, i_clk, i_rst_n, !o_in_ready,
        r_job_valid && r_res_valid, "input stalled with room")
    `PFE_ASSERT_SAME(a_last_odd, i_clk, i_rst_n, o_out_valid && o_out.run_last,
        r_res_idx[0], "run ends mid pair")
    `PFE_ASSERT_NEXT(a_drop_pend, i_clk, i_rst_n, in_xfer && i_in.word_end,
        !r_pend_valid, "letter held after word end")

endmodule

// File: bench/playfair_digraph_encryptor_tb.sv
// Self-checking testbench for the Playfair digraph encryptor: directed pairs, then random text.
module playfair_digraph_encryptor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfe_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int SETTLE_CYCLES = 8;
    localparam byte LOWER_A = "a";

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ROW_W-1:0]     i_cfg_data = '0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          err_count = 0;

    // Shadow of the key square and the pairing state
    logic [ROW_W-1:0]    key_rows [SQ_SIZE];
    logic [ROW_W-1:0]    next_square [SQ_SIZE];
    logic                held_valid = 1'b0;
    logic [LETTER_W-1:0] held_letter = '0;
    logic [LETTER_W-1:0] prev_plain = '0;
    t_out_item           cipher_q [$];

    playfair_digraph_encryptor uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [LETTER_W-1:0] square_cell(input int r, input int c);
        return key_rows[r][c*LETTER_W +: LETTER_W];
    endfunction

    // Scan backwards so the first match in row-major order is the one kept;
    // a letter not in the square takes the top-left position.
    function automatic void find_letter(input logic [LETTER_W-1:0] letter,
                                        output int r, output int c);
        r = 0;
        c = 0;
        for (int rr = SQ_SIZE - 1; rr >= 0; rr--)
            for (int cc = SQ_SIZE - 1; cc >= 0; cc--)
                if (square_cell(rr, cc) == letter) begin
                    r = rr;
                    c = cc;
                end
    endfunction

    function automatic void encrypt_pair(input logic [LETTER_W-1:0] first, second);
        int ra, ca, rb, cb, t;
        find_letter(first, ra, ca);
        // identical letters share one position
        if (first == second) begin
            rb = ra;
            cb = ca;
        end else begin
            find_letter(second, rb, cb);
        end
        if (ra == rb) begin
            ca = (ca + 1) % SQ_SIZE;
            cb = (cb + 1) % SQ_SIZE;
        end else if (ca == cb) begin
            ra = (ra + 1) % SQ_SIZE;
            rb = (rb + 1) % SQ_SIZE;
        end else begin
            t  = ca;
            ca = cb;
            cb = t;
        end
        cipher_q.push_back(t_out_item'{cipher_letter: square_cell(ra, ca), run_last: 1'b0});
        cipher_q.push_back(t_out_item'{cipher_letter: square_cell(rb, cb), run_last: 1'b0});
    endfunction

    function automatic void predict_letter(input t_in_item item);
        logic [LETTER_W-1:0] letter;
        int                  base;
        t_out_item           tail;
        letter = (item.plain_letter == LETTER_J) ? LETTER_I : item.plain_letter;
        base   = cipher_q.size();
        if (!held_valid) begin
            if (item.word_end) begin
                encrypt_pair(letter, LETTER_X);
            end else begin
                held_valid  = 1'b1;
                held_letter = letter;
            end
        end else if (held_letter != letter) begin
            encrypt_pair(held_letter, letter);
            held_valid  = 1'b0;
            held_letter = '0;
        end else begin
            // doubled letter: pad with X, the repeat starts the next pair
            encrypt_pair(held_letter, LETTER_X);
            if (item.word_end) begin
                encrypt_pair(letter, LETTER_X);
                held_valid  = 1'b0;
                held_letter = '0;
            end
        end
        if (cipher_q.size() > base) begin
            tail = cipher_q.pop_back();
            tail.run_last = 1'b1;
            cipher_q.push_back(tail);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cipher_q.size() == 0) begin
                $display("%0t: cipher letter %0d (last %0b) with none expected",
                         $time, o_out.cipher_letter, o_out.run_last);
                err_count++;
            end else begin
                due = cipher_q.pop_front();
                if (o_out.cipher_letter !== due.cipher_letter) begin
                    $display("%0t: cipher_letter expected %0d got %0d",
                             $time, due.cipher_letter, o_out.cipher_letter);
                    err_count++;
                end
                if (o_out.run_last !== due.run_last) begin
                    $display("%0t: run_last expected %0b got %0b",
                             $time, due.run_last, o_out.run_last);
                    err_count++;
                end
            end
        end
    end

    task automatic send_letter(input logic [LETTER_W-1:0] letter, input logic last);
        t_in_item item;
        item.plain_letter = letter;
        item.word_end     = last;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_in       <= t_in_item'{plain_letter: LETTER_W'($urandom), word_end: 1'($urandom)};
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (!o_in_ready);
        predict_letter(item);
        prev_plain = letter;
        @(negedge i_clk);
    endtask

    task automatic send_word(input string text);
        for (int i = 0; i < text.len(); i++)
            send_letter(LETTER_W'(text[i] - LOWER_A), i == text.len() - 1);
    endtask

    // Drop valid and hold until every expected letter has left the block.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (cipher_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx <= REG_ROW_FOUR)
            key_rows[idx] = data;
        @(negedge i_clk);
    endtask

    task automatic load_square();
        settle();
        write_reg(REG_ROW_ZERO, next_square[0]);
        write_reg(REG_ROW_ONE, next_square[1]);
        write_reg(REG_ROW_TWO, next_square[2]);
        write_reg(REG_ROW_THREE, next_square[3]);
        write_reg(REG_ROW_FOUR, next_square[4]);
        // an index past the last row must leave the square alone
        write_reg(REG_UNUSED, ROW_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void build_square(input bit shuffle);
        logic [LETTER_W-1:0] cells [CELLS];
        logic [LETTER_W-1:0] t;
        int                  k, j;
        k = 0;
        for (int code = 0; code < 26; code++)
            if (code != LETTER_J) begin
                cells[k] = LETTER_W'(code);
                k++;
            end
        if (shuffle)
            for (int i = CELLS - 1; i > 0; i--) begin
                j        = $urandom_range(i);
                t        = cells[i];
                cells[i] = cells[j];
                cells[j] = t;
            end
        for (int i = 0; i < CELLS; i++)
            next_square[i / SQ_SIZE][(i % SQ_SIZE)*LETTER_W +: LETTER_W] = cells[i];
    endfunction

    // Mostly plain letters, with doubled letters, J and out-of-alphabet codes mixed in.
    function automatic logic [LETTER_W-1:0] text_letter();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return LETTER_W'($urandom_range(31, 26));
        if (pick < 28)
            return prev_plain;
        if (pick < 33)
            return LETTER_J;
        return LETTER_W'($urandom_range(25));
    endfunction

    task automatic test_blank_square();
        send_word("ab");
        settle();
    endtask

    task automatic test_pairing_rules();
        build_square(1'b0);
        load_square();
        send_word("hello");
        send_word("j");
        send_word("ij");
        send_word("ee");
        send_word("xx");
        send_word("ae");
        send_word("ez");
        send_word("az");
        send_letter(LETTER_W'(26), 1'b0);
        send_letter(LETTER_W'(31), 1'b1);
        send_letter(LETTER_W'(28), 1'b1);
        settle();
    endtask

    task automatic test_square_extremes();
        foreach (next_square[r]) next_square[r] = '1;
        load_square();
        send_word("x");
        send_letter(LETTER_W'(31), 1'b1);
        foreach (next_square[r]) next_square[r] = '0;
        load_square();
        send_word("q");
        settle();
    endtask

    task automatic test_random_text(input int count, input int unsigned idle_pct,
                                    input int unsigned stall_pct, input bit pause_halfway);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            if (pause_halfway && n == count / 2)
                settle();
            send_letter(text_letter(), $urandom_range(99) < 25);
        end
        settle();
    endtask

    initial begin
        foreach (key_rows[r]) key_rows[r] = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_blank_square();
        test_pairing_rules();
        test_square_extremes();

        build_square(1'b1);
        load_square();
        test_random_text(65, 0, 0, 1'b0);

        build_square(1'b1);
        load_square();
        test_random_text(65, 62, 0, 1'b1);

        // random cells: duplicates, missing letters and codes past z
        foreach (next_square[r]) next_square[r] = ROW_W'($urandom);
        load_square();
        test_random_text(65, 0, 62, 1'b0);

        build_square(1'b1);
        load_square();
        test_random_text(65, 29, 29, 1'b0);

        settle();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/pfe_pkg.sv
rtl/playfair_digraph_encryptor.sv
bench/playfair_digraph_encryptor_tb.sv
